FILE: hdl/imu_rvc_frame_parser_yaw_rate_core_assert.svh
// Assertion macros used by the frame parser controller.
`ifndef IMU_RVC_FRAME_PARSER_YAW_RATE_CORE_ASSERT_SVH
`define IMU_RVC_FRAME_PARSER_YAW_RATE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define RVCYAW_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define RVCYAW_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVCYAW_ASSERT(name, prop, msg)
`define RVCYAW_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: hdl/rvcyaw_pkg.sv
// Types and constants shared by the frame parser controller and datapath.
`default_nettype none
package rvcyaw_pkg;
	localparam logic [7:0] HDR_BYTE = 8'hAA;
	localparam int unsigned BODY_LEN = 16;
	localparam int unsigned POS_W = $clog2(BODY_LEN + 1);
	localparam int unsigned DIFF_W = 17;
	localparam int unsigned MAG_W = 25;
	localparam int unsigned RATE_W = 26;
	localparam int unsigned DIV_STEPS = MAG_W;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);
	localparam logic [10:0] RATE_SCALE = 11'd1144;
	localparam logic signed [DIFF_W-1:0] HALF_TURN = 17'sd18000;
	localparam logic signed [DIFF_W-1:0] FULL_TURN = 17'sd36000;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_HDR2,
		ST_BODY,
		ST_WRAP,
		ST_MUL,
		ST_DIV,
		ST_SIGN,
		ST_LOAD
	} ctrl_state_t;

	typedef struct packed {
		logic shift_byte;
		logic clear_sum;
		logic capture;
		logic wrap_step;
		logic mul;
		logic div_step;
		logic sign;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic hdr_match;
		logic chk_ok;
		logic prev_valid;
		logic wrap_done;
	} dp_sts_t;
endpackage
`default_nettype wire

FILE: hdl/rvcyaw_dp.sv
// Datapath: frame byte store, checksum, yaw difference, multiplier and serial divider.
`default_nettype none
module rvcyaw_dp
	import rvcyaw_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [7:0]               rx_byte,
	input  wire dp_cmd_t                  cmd,
	output dp_sts_t                       sts,
	output logic [7:0]                    sample_index,
	output logic signed [15:0]            yaw_centideg,
	output logic signed [15:0]            pitch_centideg,
	output logic signed [15:0]            roll_centideg,
	output logic signed [15:0]            accel_x_milli_g,
	output logic signed [15:0]            accel_y_milli_g,
	output logic signed [15:0]            accel_z_milli_g,
	output logic signed [RATE_W-1:0]      yaw_rate_q16,
	output logic                          rate_valid
);
	logic [7:0]               body_q [BODY_LEN];
	logic [7:0]               sum_q;
	logic                     prev_valid_q;
	logic [7:0]               prev_idx_q;
	logic [15:0]              prev_yaw_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [7:0]               step_q;
	logic                     neg_q;
	logic [MAG_W-1:0]         quo_q;
	logic [7:0]               rem_q;
	logic signed [RATE_W-1:0] rate_q;
	logic                     rate_valid_q;

	logic [7:0]               idx_now;
	logic [15:0]              yaw_now;
	logic [7:0]               step_raw;
	logic [DIFF_W-1:0]        diff_abs;
	logic [9:0]               trial;

	assign idx_now  = body_q[0];
	assign yaw_now  = {body_q[2], body_q[1]};
	assign step_raw = idx_now - prev_idx_q;
	assign diff_abs = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
	assign trial    = {1'b0, rem_q, quo_q[MAG_W-1]} - {2'b00, step_q};

	assign sts.hdr_match  = (rx_byte == HDR_BYTE);
	assign sts.chk_ok     = (rx_byte == sum_q);
	assign sts.prev_valid = prev_valid_q;
	assign sts.wrap_done  = (diff_q <= HALF_TURN) && (diff_q >= -HALF_TURN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_idx_q   <= '0;
			prev_yaw_q   <= '0;
		end else if (cmd.capture) begin
			prev_valid_q <= 1'b1;
			prev_idx_q   <= idx_now;
			prev_yaw_q   <= yaw_now;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			for (int i = 0; i < BODY_LEN - 1; i++) begin
				body_q[i] <= body_q[i+1];
			end
			body_q[BODY_LEN-1] <= rx_byte;
		end
		if (cmd.clear_sum) begin
			sum_q <= '0;
		end else if (cmd.shift_byte) begin
			sum_q <= sum_q + rx_byte;
		end
		if (cmd.capture) begin
			diff_q       <= DIFF_W'($signed(yaw_now)) - DIFF_W'($signed(prev_yaw_q));
			step_q       <= (step_raw == 8'd0) ? 8'd1 : step_raw;
			rate_valid_q <= prev_valid_q;
			rate_q       <= '0;
		end else if (cmd.wrap_step) begin
			if (diff_q > HALF_TURN) begin
				diff_q <= diff_q - FULL_TURN;
			end else begin
				diff_q <= diff_q + FULL_TURN;
			end
		end
		if (cmd.mul) begin
			neg_q <= diff_q[DIFF_W-1];
			quo_q <= MAG_W'(diff_abs[14:0]) * MAG_W'(RATE_SCALE);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[9]) begin
				rem_q <= trial[7:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[6:0], quo_q[MAG_W-1]};
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
		if (cmd.sign) begin
			rate_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		end
		if (cmd.load) begin
			sample_index    <= idx_now;
			yaw_centideg    <= $signed(yaw_now);
			pitch_centideg  <= $signed({body_q[4], body_q[3]});
			roll_centideg   <= $signed({body_q[6], body_q[5]});
			accel_x_milli_g <= $signed({body_q[8], body_q[7]});
			accel_y_milli_g <= $signed({body_q[10], body_q[9]});
			accel_z_milli_g <= $signed({body_q[12], body_q[11]});
			yaw_rate_q16    <= rate_q;
			rate_valid      <= rate_valid_q;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/rvcyaw_ctrl.sv
// Controller: frame parsing state machine and sequencing of the rate computation.
`default_nettype none
`include "imu_rvc_frame_parser_yaw_rate_core_assert.svh"
module rvcyaw_ctrl
	import rvcyaw_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);
	ctrl_state_t      state_q, state_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HUNT;
			pos_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pos_q       <= pos_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// In the states that take bytes the input never stalls, so in_valid alone
	// marks a taken byte there.
	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_HUNT: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = sts.hdr_match ? ST_HDR2 : ST_HUNT;
				end
			end
			ST_HDR2: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (sts.hdr_match) begin
						cmd.clear_sum = 1'b1;
						pos_d         = '0;
						state_d       = ST_BODY;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_BODY: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (pos_q < POS_W'(BODY_LEN)) begin
						cmd.shift_byte = 1'b1;
						pos_d          = pos_q + 1'b1;
					end else begin
						pos_d = '0;
						if (sts.chk_ok) begin
							cmd.capture = 1'b1;
							state_d     = sts.prev_valid ? ST_WRAP : ST_LOAD;
						end else begin
							state_d = ST_HUNT;
						end
					end
				end
			end
			ST_WRAP: begin
				if (sts.wrap_done) begin
					state_d = ST_MUL;
				end else begin
					cmd.wrap_step = 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				cmd.sign = 1'b1;
				state_d  = ST_LOAD;
			end
			ST_LOAD: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load = 1'b1;
					state_d  = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	always_comb begin
		if (cmd.load) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	`RVCYAW_ASSERT(a_pos_range, pos_q <= POS_W'(BODY_LEN), "body position past frame end")
	`RVCYAW_ASSERT(a_cnt_range, (state_q == ST_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)), "divider count overrun")
	`RVCYAW_ASSERT(a_load_free, cmd.load |-> (!out_valid_q || !out_stall), "result overwritten while stalled")
	`RVCYAW_ASSERT(a_load_shows, cmd.load |=> out_valid_q, "loaded result not presented")
	`RVCYAW_ASSERT(a_busy_stalls, (state_q == ST_DIV || state_q == ST_WRAP) |-> in_stall, "byte taken during computation")
endmodule
`default_nettype wire

FILE: hdl/imu_rvc_frame_parser_yaw_rate_core.sv
// Top level of the serial orientation frame parser with yaw rate output.
//
// The input channel carries one received UART byte per request (rx_byte), moved when
// in_valid is high and in_stall is low. The parser hunts for the header 0xAA 0xAA,
// collects sixteen body bytes and a checksum byte, and drops frames whose 8-bit sum
// does not match. A good frame produces one request on the output channel carrying
// the sample index, yaw, pitch, roll, the three accelerations and the yaw rate.
//
// Bytes are taken at one per cycle while parsing. After a good checksum byte the input
// stalls while the rate is worked out in the states for angle wrapping, the multiply,
// a bit-serial restoring divider, the sign and the load, in that order; the divider
// takes longest. The first frame after reset has no rate to compute, so its checksum
// byte leads straight to the load state.
// The result waits in an output register; the parser keeps taking bytes while the
// receiver stalls, and only holds the next finished frame until that register frees.
// Reset returns the parser to header hunting and forgets the previous frame, so the
// first frame afterwards reports rate_valid low and a zero rate.
`default_nettype none
module imu_rvc_frame_parser_yaw_rate_core
	import rvcyaw_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          rx_byte,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [7:0]               sample_index,
	output logic signed [15:0]       yaw_centideg,
	output logic signed [15:0]       pitch_centideg,
	output logic signed [15:0]       roll_centideg,
	output logic signed [15:0]       accel_x_milli_g,
	output logic signed [15:0]       accel_y_milli_g,
	output logic signed [15:0]       accel_z_milli_g,
	output logic signed [RATE_W-1:0] yaw_rate_q16,
	output logic                     rate_valid
);
	// Commands flow from the controller to the datapath, status flows back.
	dp_cmd_t cmd;
	dp_sts_t sts;

	rvcyaw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the frame bytes, the previous frame's index and yaw,
	// and the output payload register.
	rvcyaw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_byte         (rx_byte),
		.cmd             (cmd),
		.sts             (sts),
		.sample_index    (sample_index),
		.yaw_centideg    (yaw_centideg),
		.pitch_centideg  (pitch_centideg),
		.roll_centideg   (roll_centideg),
		.accel_x_milli_g (accel_x_milli_g),
		.accel_y_milli_g (accel_y_milli_g),
		.accel_z_milli_g (accel_z_milli_g),
		.yaw_rate_q16    (yaw_rate_q16),
		.rate_valid      (rate_valid)
	);
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the serial orientation frame parser with yaw rate.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rvcyaw_pkg::*;

	// Bytes to push through the parser in total, directed frames included.
	localparam int STIM_BYTES = 1150;
	// Cycles with no transfer on either channel before the run is declared hung.
	// The worst correct case is a long sender gap stacked on a long receiver stall
	// and the divider's run.
	localparam int STALL_LIMIT = 4000;
	// Cycles allowed after the last expected frame, well past the rate pipeline.
	localparam int DRAIN_CYCLES = 64;
	localparam int DIR_ROWS = 10;

	// One finished frame as the output channel presents it.
	typedef struct packed {
		logic [7:0]              idx;
		logic signed [15:0]      yaw;
		logic signed [15:0]      pitch;
		logic signed [15:0]      roll;
		logic signed [15:0]      ax;
		logic signed [15:0]      ay;
		logic signed [15:0]      az;
		logic signed [RATE_W-1:0] rate;
		logic                    rvalid;
	} frame_res_t;

	// Where the shadow parser stands in the byte stream.
	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HDR2,
		PH_BODY
	} hunt_phase_t;

	typedef enum logic {
		FR_GOOD,
		FR_BADSUM
	} frame_kind_t;

	// One directed frame: up to two loose bytes sent ahead of it, the frame fields,
	// and, where the answer is obvious, the rate fields it must produce.
	typedef struct packed {
		logic [1:0]         pre_n;
		logic [15:0]        pre;
		frame_kind_t        kind;
		logic [7:0]         idx;
		logic [15:0]        yaw;
		logic [15:0]        pitch;
		logic [15:0]        roll;
		logic [15:0]        ax;
		logic [15:0]        ay;
		logic [15:0]        az;
		logic [7:0]         pad;
		logic               typed;
		logic signed [25:0] t_rate;
		logic               t_valid;
	} dir_row_t;

	// Directed frames. Rows 3 to 6 walk yaw around the half-turn boundary with an
	// index step of one, so the rate hits both extremes and the full-turn wrap.
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// First frame after reset: all fields and the pad byte zero, no rate yet.
		'{2'd2, 16'h00FF, FR_GOOD, 8'd0, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 26'sd0, 1'b0},
		// Broken second header ahead of it; same index counts as a step of one.
		'{2'd2, 16'hAA55, FR_GOOD, 8'd0, 16'h0000, 16'h7FFF, 16'h8000,
			16'h7FFF, 16'h8000, 16'hFFFF, 8'hFF, 1'b1, 26'sd0, 1'b1},
		// Bad checksum: dropped, previous index and yaw stay put.
		'{2'd0, 16'h0000, FR_BADSUM, 8'd5, 16'd5000, 16'h1111, 16'h2222,
			16'h3333, 16'h4444, 16'h5555, 8'h66, 1'b0, 26'sd0, 1'b0},
		'{2'd0, 16'h0000, FR_GOOD, 8'd1, 16'd18000, 16'h0001, 16'h0002,
			16'h0003, 16'h0004, 16'h0005, 8'h00, 1'b1, 26'sd20592000, 1'b1},
		'{2'd0, 16'h0000, FR_GOOD, 8'd2, -16'sd18000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 26'sd0, 1'b1},
		'{2'd0, 16'h0000, FR_GOOD, 8'd3, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 26'sd20592000, 1'b1},
		'{2'd0, 16'h0000, FR_GOOD, 8'd4, -16'sd18000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, -26'sd20592000, 1'b1},
		// Index going backwards gives a step of 255.
		'{2'd0, 16'h0000, FR_GOOD, 8'd3, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000, 16'h7FFF, 16'h8000, 8'h01, 1'b0, 26'sd0, 1'b0},
		// Yaw swing from the top to the bottom of the range needs two wraps.
		'{2'd0, 16'h0000, FR_GOOD, 8'hFF, 16'h8000, 16'h5A5A, 16'hA5A5,
			16'h1234, 16'hEDCB, 16'h0F0F, 8'hAA, 1'b0, 26'sd0, 1'b0},
		// A stray header byte ahead of the real header shifts the whole frame by one.
		'{2'd1, 16'h00AA, FR_GOOD, 8'hAA, 16'hAAAA, 16'hAAAA, 16'h55AA,
			16'hAA55, 16'h0000, 16'hFFFF, 8'hAA, 1'b0, 26'sd0, 1'b0}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] sample_index;
	logic signed [15:0] yaw_centideg;
	logic signed [15:0] pitch_centideg;
	logic signed [15:0] roll_centideg;
	logic signed [15:0] accel_x_milli_g;
	logic signed [15:0] accel_y_milli_g;
	logic signed [15:0] accel_z_milli_g;
	logic signed [RATE_W-1:0] yaw_rate_q16;
	logic rate_valid;

	// Shadow copy of the parser state, starting from its reset values.
	hunt_phase_t hunt_st = PH_HUNT;
	logic [7:0] body_q [BODY_LEN];
	int body_cnt = 0;
	bit prior_ok = 1'b0;
	logic [7:0] prior_idx = 8'h00;
	logic signed [15:0] prior_yaw = 16'sh0000;

	// Frames the parser owes us, oldest first.
	frame_res_t expected_frames [$];
	int miss_count = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	// When set, the sender or the receiver runs back to back with no idling.
	bit tx_quiet = 1'b1;
	bit rx_quiet = 1'b1;

	imu_rvc_frame_parser_yaw_rate_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sample_index    (sample_index),
		.yaw_centideg    (yaw_centideg),
		.pitch_centideg  (pitch_centideg),
		.roll_centideg   (roll_centideg),
		.accel_x_milli_g (accel_x_milli_g),
		.accel_y_milli_g (accel_y_milli_g),
		.accel_z_milli_g (accel_z_milli_g),
		.yaw_rate_q16    (yaw_rate_q16),
		.rate_valid      (rate_valid)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Length of one idle stretch, in cycles, drawn at random from four ranges.
	function automatic int idle_len();
		int roll_dice;
		roll_dice = $urandom_range(0, 99);
		if (roll_dice < 55) return $urandom_range(1, 2);
		if (roll_dice < 90) return $urandom_range(3, 6);
		if (roll_dice < 98) return $urandom_range(8, 25);
		return $urandom_range(60, 150);
	endfunction

	// Advances the shadow parser by one received byte. Returns 1 when the byte
	// completes a frame with a good checksum, with the frame the block must emit.
	function automatic bit parse_rx_byte(input logic [7:0] b, output frame_res_t r);
		logic [7:0] csum;
		logic [7:0] idx_step;
		int d;
		int divisor;
		r = '0;
		case (hunt_st)
			PH_HDR2: begin
				// A wrong second header byte is dropped, not retried as a first one.
				hunt_st = (b == HDR_BYTE) ? PH_BODY : PH_HUNT;
				body_cnt = 0;
				return 1'b0;
			end
			PH_BODY: begin
				if (body_cnt < BODY_LEN) begin
					body_q[body_cnt] = b;
					body_cnt++;
					return 1'b0;
				end
				csum = 8'h00;
				for (int i = 0; i < BODY_LEN; i++) csum = csum + body_q[i];
				hunt_st = PH_HUNT;
				body_cnt = 0;
				if (csum != b) return 1'b0;
			end
			default: begin
				hunt_st = (b == HDR_BYTE) ? PH_HDR2 : PH_HUNT;
				return 1'b0;
			end
		endcase

		r.idx = body_q[0];
		r.yaw = {body_q[2], body_q[1]};
		r.pitch = {body_q[4], body_q[3]};
		r.roll = {body_q[6], body_q[5]};
		r.ax = {body_q[8], body_q[7]};
		r.ay = {body_q[10], body_q[9]};
		r.az = {body_q[12], body_q[11]};
		if (prior_ok) begin
			// Fold the yaw change into one half turn either way.
			d = int'(r.yaw) - int'(prior_yaw);
			while (d > int'(HALF_TURN)) d -= int'(FULL_TURN);
			while (d < -int'(HALF_TURN)) d += int'(FULL_TURN);
			idx_step = r.idx - prior_idx;
			divisor = (idx_step == 8'h00) ? 1 : int'(idx_step);
			r.rate = RATE_W'((d * int'(RATE_SCALE)) / divisor);
			r.rvalid = 1'b1;
		end
		prior_ok = 1'b1;
		prior_idx = r.idx;
		prior_yaw = r.yaw;
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		miss_count++;
		if (miss_count <= 100)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Offers one byte on the input channel and holds it until the parser takes it.
	// A typed expectation, where given, replaces the shadow parser's frame.
	task automatic send_byte(input logic [7:0] b, input bit typed, input frame_res_t tres);
		int gap;
		frame_res_t r;
		gap = 0;
		if (!tx_quiet && $urandom_range(0, 2) == 0) gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		if (parse_rx_byte(b, r)) expected_frames.push_back(typed ? tres : r);
	endtask

	// Sends header, sixteen body bytes and checksum. A nonzero csum_err spoils
	// the checksum by that amount.
	task automatic send_frame(input logic [7:0] idx, input logic [15:0] yaw,
			input logic [15:0] pitch, input logic [15:0] roll, input logic [15:0] ax,
			input logic [15:0] ay, input logic [15:0] az, input logic [7:0] pad,
			input logic [7:0] csum_err, input bit typed,
			input logic signed [25:0] t_rate, input bit t_valid);
		logic [7:0] body [BODY_LEN];
		logic [7:0] csum;
		frame_res_t tres;
		body = '{idx, yaw[7:0], yaw[15:8], pitch[7:0], pitch[15:8], roll[7:0],
			roll[15:8], ax[7:0], ax[15:8], ay[7:0], ay[15:8], az[7:0], az[15:8],
			pad, 8'h00, 8'h00};
		// The last two body bytes are reserved fields; fill them from the pad byte too.
		body[14] = pad ^ 8'h5A;
		body[15] = ~pad;
		csum = 8'h00;
		for (int i = 0; i < BODY_LEN; i++) csum = csum + body[i];
		tres = '{idx, yaw, pitch, roll, ax, ay, az, t_rate, t_valid};
		send_byte(HDR_BYTE, 1'b0, tres);
		send_byte(HDR_BYTE, 1'b0, tres);
		for (int i = 0; i < BODY_LEN; i++) send_byte(body[i], 1'b0, tres);
		send_byte(csum + csum_err, typed, tres);
	endtask

	// Receiver: stalls in bursts of random length unless told to stay quiet.
	initial begin
		int stall_run;
		stall_run = 0;
		forever begin
			@(negedge clk);
			if (rx_quiet) begin
				out_stall <= 1'b0;
				stall_run = 0;
			end else if (stall_run > 0) begin
				out_stall <= 1'b1;
				stall_run--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0) stall_run = idle_len();
			end
		end
	end

	// Every accepted output request is checked against the oldest expected frame.
	always @(posedge clk) begin
		frame_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				note_mismatch("unexpected frame, sample_index", sample_index, -1);
			end else begin
				want = expected_frames.pop_front();
				if (sample_index !== want.idx)
					note_mismatch("sample_index", sample_index, want.idx);
				if (yaw_centideg !== want.yaw)
					note_mismatch("yaw_centideg", yaw_centideg, want.yaw);
				if (pitch_centideg !== want.pitch)
					note_mismatch("pitch_centideg", pitch_centideg, want.pitch);
				if (roll_centideg !== want.roll)
					note_mismatch("roll_centideg", roll_centideg, want.roll);
				if (accel_x_milli_g !== want.ax)
					note_mismatch("accel_x_milli_g", accel_x_milli_g, want.ax);
				if (accel_y_milli_g !== want.ay)
					note_mismatch("accel_y_milli_g", accel_y_milli_g, want.ay);
				if (accel_z_milli_g !== want.az)
					note_mismatch("accel_z_milli_g", accel_z_milli_g, want.az);
				if (yaw_rate_q16 !== want.rate)
					note_mismatch("yaw_rate_q16", yaw_rate_q16, want.rate);
				if (rate_valid !== want.rvalid)
					note_mismatch("rate_valid", rate_valid, want.rvalid);
			end
		end
	end

	// Watchdog: a stretch with no transfer on either channel means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t row;
		int pick;
		int roll_dice;
		int idx_jump;
		int yaw_jump;
		logic [7:0] last_idx;
		logic [15:0] last_yaw;
		logic [7:0] cur_idx;
		logic [15:0] cur_yaw;
		logic [7:0] junk;
		bit bad;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames. The first few run with no idling on either side, the
		// rest with the usual random gaps and stalls.
		for (int n = 0; n < DIR_ROWS; n++) begin
			row = DIR_TAB[n];
			tx_quiet = (n < 5);
			rx_quiet = (n < 5);
			if (row.pre_n == 2'd2) send_byte(row.pre[15:8], 1'b0, '0);
			if (row.pre_n != 2'd0) send_byte(row.pre[7:0], 1'b0, '0);
			send_frame(row.idx, row.yaw, row.pitch, row.roll, row.ax, row.ay, row.az,
				row.pad, (row.kind == FR_BADSUM) ? 8'h01 : 8'h00, row.typed,
				row.t_rate, row.t_valid);
		end

		// Random part: mostly well-formed frames with plausible yaw motion, so the
		// rate path gets real work, mixed with spoiled checksums, loose noise bytes
		// and broken headers.
		last_idx = 8'h00;
		last_yaw = 16'h0000;
		while (bytes_sent < STIM_BYTES) begin
			if ($urandom_range(0, 14) == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 88) begin
				bad = (pick >= 80);
				roll_dice = $urandom_range(0, 99);
				if (roll_dice < 70) idx_jump = 1;
				else if (roll_dice < 80) idx_jump = 0;
				else idx_jump = $urandom_range(0, 255);
				cur_idx = last_idx + 8'(idx_jump);
				roll_dice = $urandom_range(0, 99);
				if (roll_dice < 55) yaw_jump = int'($urandom_range(0, 8000)) - 4000;
				else if (roll_dice < 75) yaw_jump = int'($urandom_range(0, 65535));
				else if (roll_dice < 90)
					yaw_jump = ($urandom_range(0, 1) ? 1 : -1)
						* (17990 + int'($urandom_range(0, 20)));
				else yaw_jump = 0;
				if (roll_dice >= 90) cur_yaw = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				else cur_yaw = last_yaw + 16'(yaw_jump);
				send_frame(cur_idx, cur_yaw, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 8'($urandom),
					bad ? 8'($urandom_range(1, 255)) : 8'h00, 1'b0, 26'sd0, 1'b0);
				if (!bad) begin
					last_idx = cur_idx;
					last_yaw = cur_yaw;
				end
			end else if (pick < 94) begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0, '0);
			end else begin
				junk = 8'($urandom);
				if (junk == HDR_BYTE) junk = 8'h00;
				send_byte(HDR_BYTE, 1'b0, '0);
				send_byte(junk, 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (miss_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/rvcyaw_pkg.sv
hdl/rvcyaw_dp.sv
hdl/rvcyaw_ctrl.sv
hdl/imu_rvc_frame_parser_yaw_rate_core.sv
dv/tb.sv
